### rtl/websocket_frame_receiver_assert.svh
// Assertion helpers used by the checker file of the frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

### rtl/wsfr_pkg.sv
package wsfr_pkg;

    // Frame parsing phase, one-hot.
    typedef enum logic [3:0] {
        PH_FIRST   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CLOSED  = 4'b1000
    } phase_t;

    // Result kind codes.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_CLOSED  = 2'd2
    } kind_t;

    // Event codes reported on the result channel.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_FRAGMENT = 3'd1;
    localparam logic [2:0] EV_MESSAGE  = 3'd2;
    localparam logic [2:0] EV_PING     = 3'd3;
    localparam logic [2:0] EV_CLOSE    = 3'd4;
    localparam logic [2:0] EV_PONG     = 3'd5;
    localparam logic [2:0] EV_OTHER    = 3'd6;
    localparam logic [2:0] EV_TOO_BIG  = 3'd7;

    // Opcodes that matter for event reporting.
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Length codes that select an extended length field.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [31:0] DEFAULT_MAX_MESSAGE = 32'd8388608;

    // Per-frame parser state.
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  header_index;
        logic [7:0]  first_header_byte;
        logic        mask_flag;
        logic [6:0]  length_code;
        logic [31:0] mask_key;
        logic [63:0] remaining_payload;
        logic [1:0]  key_index;
    } frame_state_t;

    // One result beat.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic        frame_end;
        logic [2:0]  event_res;
        logic [31:0] message_length;
    } result_t;

    // Number of extended length bytes for a 7-bit length code.
    function automatic logic [3:0] ext_bytes(input logic [6:0] code);
        logic [3:0] n;
        n = 4'd0;
        if (code == LEN_CODE_16) begin
            n = 4'd2;
        end else if (code == LEN_CODE_64) begin
            n = 4'd8;
        end
        return n;
    endfunction

endpackage

### rtl/wsfr_parser.sv
module wsfr_parser #(
    parameter int MSG_LEN_BITS = 32
) (
    input  wsfr_pkg::frame_state_t    cur,
    input  logic [MSG_LEN_BITS-1:0]   acc,
    input  logic [31:0]               max_message_bytes,
    input  logic [7:0]                rx_byte,
    output wsfr_pkg::frame_state_t    nxt,
    output logic [MSG_LEN_BITS-1:0]   acc_out,
    output wsfr_pkg::result_t         res
);
    import wsfr_pkg::*;

    localparam int RW = (MSG_LEN_BITS < 32) ? MSG_LEN_BITS : 32;
    localparam int SW = ((MSG_LEN_BITS > 64) ? MSG_LEN_BITS : 64) + 1;

    logic [MSG_LEN_BITS-1:0] acc_rep;
    logic [3:0]              hdr_len;
    logic [SW-1:0]           total;
    logic                    end_flag;
    logic [2:0]              ev_end;
    logic [3:0]              op;
    logic [7:0]              key_byte;

    // Event that a completed frame reports.
    always_comb begin
        op = cur.first_header_byte[3:0];
        if (!cur.first_header_byte[7]) begin
            ev_end = EV_FRAGMENT;
        end else begin
            case (op)
                OP_CONT, OP_TEXT, OP_BIN: ev_end = EV_MESSAGE;
                OP_PING:                  ev_end = EV_PING;
                OP_CLOSE:                 ev_end = EV_CLOSE;
                OP_PONG:                  ev_end = EV_PONG;
                default:                  ev_end = EV_OTHER;
            endcase
        end
    end

    // Mask key byte selected by the rotating index, most significant first.
    always_comb begin
        case (cur.key_index)
            2'd0:    key_byte = cur.mask_key[31:24];
            2'd1:    key_byte = cur.mask_key[23:16];
            2'd2:    key_byte = cur.mask_key[15:8];
            default: key_byte = cur.mask_key[7:0];
        endcase
    end

    // Next state and result for one byte.
    always_comb begin
        nxt                = cur;
        acc_rep            = acc;
        acc_out            = acc;
        end_flag           = 1'b0;
        hdr_len            = 4'd0;
        total              = '0;
        res.kind           = KIND_HEADER;
        res.payload_byte   = 8'd0;
        res.frame_opcode   = cur.first_header_byte[3:0];
        res.frame_end      = 1'b0;
        res.event_res      = EV_NONE;
        res.message_length = 32'd0;

        case (cur.phase)
            PH_FIRST: begin
                nxt.first_header_byte = rx_byte;
                res.frame_opcode      = rx_byte[3:0];
                nxt.header_index      = 4'd1;
                nxt.phase             = PH_HEADER;
            end
            PH_HEADER: begin
                // Second byte, extended length bytes, then the mask key.
                if (cur.header_index <= 4'd1) begin
                    nxt.mask_flag   = rx_byte[7];
                    nxt.length_code = rx_byte[6:0];
                    nxt.remaining_payload = (rx_byte[6:0] < LEN_CODE_16) ?
                        64'(rx_byte[6:0]) : 64'd0;
                    nxt.mask_key    = 32'd0;
                end else if (cur.header_index < 4'd2 + ext_bytes(cur.length_code)) begin
                    nxt.remaining_payload = {cur.remaining_payload[55:0], rx_byte};
                end else begin
                    nxt.mask_key = {cur.mask_key[23:0], rx_byte};
                end
                hdr_len = 4'd2 + ext_bytes(nxt.length_code)
                        + (nxt.mask_flag ? 4'd4 : 4'd0);
                nxt.header_index = cur.header_index + 4'd1;
                if (nxt.header_index >= hdr_len) begin
                    // Size check on every completed header.
                    total = SW'(nxt.remaining_payload) + SW'(acc);
                    if (total > SW'(max_message_bytes)) begin
                        res.event_res = EV_TOO_BIG;
                        nxt.phase     = PH_CLOSED;
                    end else if (nxt.remaining_payload == 64'd0) begin
                        end_flag = 1'b1;
                    end else begin
                        nxt.phase     = PH_PAYLOAD;
                        nxt.key_index = 2'd0;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = cur.mask_flag ? (rx_byte ^ key_byte) : rx_byte;
                nxt.key_index    = cur.key_index + 2'd1;
                if (acc != '1) begin
                    acc_rep = acc + 1'b1;
                end
                acc_out               = acc_rep;
                nxt.remaining_payload = cur.remaining_payload - 64'd1;
                if (nxt.remaining_payload == 64'd0) begin
                    end_flag = 1'b1;
                end
            end
            default: begin
                res.kind         = KIND_CLOSED;
                res.frame_opcode = 4'd0;
            end
        endcase

        // Frame completion: report the event and close or rearm.
        if (end_flag) begin
            res.frame_end    = 1'b1;
            res.event_res    = ev_end;
            nxt.header_index = 4'd0;
            nxt.phase        = (ev_end == EV_CLOSE) ? PH_CLOSED : PH_FIRST;
            if (ev_end != EV_FRAGMENT) begin
                acc_out = '0;
            end
        end

        res.message_length = 32'(acc_rep[RW-1:0]);
    end

endmodule

### rtl/websocket_frame_receiver.sv
// Frame receiver for a websocket byte stream. Bytes enter on the s_ channel and every byte
// yields exactly one result beat on the m_ channel: a header byte, an unmasked payload byte,
// or a byte dropped once the connection is closed. The last byte of each frame carries the
// event code and the accumulated message length. The block takes one byte per clock cycle
// while the m_ side keeps up; a result beat passes the input register and then the result
// register, and the frame state update that sets this rate completes in the cycle a byte
// moves from the input to the result register. After a final close frame or an oversized
// message, every byte is dropped until reset. The message size limit is written through
// cfg_wr_en and cfg_wr_data; the user must do so only while idle, as the block has no guard.
module websocket_frame_receiver #(
    parameter int MSG_LEN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [3:0]  m_frame_opcode,
    output logic        m_frame_end,
    output logic [2:0]  m_event_res,
    output logic [31:0] m_message_length
);
    import wsfr_pkg::*;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    frame_state_t            state_reg;
    frame_state_t            state_next;
    logic [MSG_LEN_BITS-1:0] acc_reg;
    logic [MSG_LEN_BITS-1:0] acc_next;
    logic [31:0]             max_reg;
    logic                    out_valid_reg;
    result_t                 out_res_reg;
    result_t                 res_next;
    logic                    advance;

    // A beat moves to the result register when that register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    wsfr_parser #(
        .MSG_LEN_BITS(MSG_LEN_BITS)
    ) u_parser (
        .cur               (state_reg),
        .acc               (acc_reg),
        .max_message_bytes (max_reg),
        .rx_byte           (in_byte_reg),
        .nxt               (state_next),
        .acc_out           (acc_next),
        .res               (res_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Frame state, accumulated length and size limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_FIRST, header_index: 4'd0, first_header_byte: 8'd0,
                           mask_flag: 1'b0, length_code: 7'd0, mask_key: 32'd0,
                           remaining_payload: 64'd0, key_index: 2'd0};
            acc_reg   <= '0;
            max_reg   <= DEFAULT_MAX_MESSAGE;
        end else begin
            if (advance) begin
                state_reg <= state_next;
                acc_reg   <= acc_next;
            end
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_res_reg.kind;
    assign m_payload_byte   = out_res_reg.payload_byte;
    assign m_frame_opcode   = out_res_reg.frame_opcode;
    assign m_frame_end      = out_res_reg.frame_end;
    assign m_event_res      = out_res_reg.event_res;
    assign m_message_length = out_res_reg.message_length;

endmodule

### rtl/wsfr_checker.sv
`include "websocket_frame_receiver_assert.svh"

module wsfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_payload_byte,
    input logic [3:0]  m_frame_opcode,
    input logic        m_frame_end,
    input logic [2:0]  m_event_res,
    input logic [31:0] m_message_length
);
    import wsfr_pkg::*;

    // A stalled result beat holds its valid and its kind, byte, frame end, event and length.
    `WSFR_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_payload_byte) && $stable(m_frame_end) && $stable(m_event_res) && $stable(m_message_length))

    // Only payload beats carry a data byte.
    `WSFR_ASSERT_SAME(a_byte_only_payload, aclk, aresetn, m_valid && (m_kind != KIND_PAYLOAD), m_payload_byte == 8'd0)

    // Dropped beats carry no opcode, frame end or event.
    `WSFR_ASSERT_SAME(a_closed_quiet, aclk, aresetn, m_valid && (m_kind == KIND_CLOSED), (m_frame_opcode == 4'd0) && !m_frame_end && (m_event_res == EV_NONE))

    // A frame end always reports a frame event, and the size event never ends a frame.
    `WSFR_ASSERT_SAME(a_end_event, aclk, aresetn, m_valid && m_frame_end, (m_event_res != EV_NONE) && (m_event_res != EV_TOO_BIG) && (m_kind != KIND_CLOSED))

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wsfr_pkg::*;

    localparam int IDLE_PCT = 29;
    localparam int TIMEOUT_NS = 1_000_000;

    // Deframer state as the predictor tracks it.
    typedef struct packed {
        phase_t      ph;
        logic [3:0]  hdr_count;
        logic [7:0]  lead_byte;
        logic        masked;
        logic [6:0]  len_code;
        logic [31:0] mask_key;
        logic [63:0] bytes_left;
        logic [1:0]  key_pos;
        logic [31:0] msg_bytes;
    } deframe_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [3:0]  m_frame_opcode;
    logic        m_frame_end;
    logic [2:0]  m_event_res;
    logic [31:0] m_message_length;

    // Bytes waiting to be driven and result beats waiting to arrive.
    logic [7:0]     byte_queue[$];
    result_t        expect_q[$];

    // Live predictor state, updated on accepted beats, and the planning copy used
    // by the stimulus to keep messages within the size limit.
    deframe_state_t live_st;
    deframe_state_t plan_st;
    logic [31:0]    live_limit;
    logic [31:0]    plan_limit;

    int unsigned taken_count = 0;
    int unsigned offered_count = 0;
    int unsigned planned = 0;
    int unsigned fail_count = 0;
    logic        quiet = 1'b0;

    websocket_frame_receiver dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_frame_opcode   (m_frame_opcode),
        .m_frame_end      (m_frame_end),
        .m_event_res      (m_event_res),
        .m_message_length (m_message_length)
    );

    always #4 aclk = ~aclk;

    function automatic deframe_state_t idle_state();
        deframe_state_t s;
        s.ph = PH_FIRST;
        s.hdr_count = '0;
        s.lead_byte = '0;
        s.masked = 1'b0;
        s.len_code = '0;
        s.mask_key = '0;
        s.bytes_left = '0;
        s.key_pos = '0;
        s.msg_bytes = '0;
        return s;
    endfunction

    // Frame finished: pick the event from FIN and opcode and return to the first header byte.
    function automatic logic [2:0] frame_event(inout deframe_state_t s);
        logic [2:0] ev;
        s.ph = PH_FIRST;
        s.hdr_count = '0;
        if (!s.lead_byte[7]) begin
            ev = EV_FRAGMENT;
        end else begin
            case (s.lead_byte[3:0])
                OP_CONT, OP_TEXT, OP_BIN: ev = EV_MESSAGE;
                OP_PING: ev = EV_PING;
                OP_CLOSE: begin
                    ev = EV_CLOSE;
                    s.ph = PH_CLOSED;
                end
                OP_PONG: ev = EV_PONG;
                default: ev = EV_OTHER;
            endcase
        end
        return ev;
    endfunction

    // Expected result beat for one received byte.
    function automatic result_t deframe_byte(inout deframe_state_t s, input logic [7:0] b,
                                             input logic [31:0] limit);
        result_t     r;
        logic [3:0]  ext_len;
        logic [3:0]  hdr_len;
        logic [63:0] lim64;
        logic [31:0] key_word;
        logic        clear_after;
        r.kind = KIND_HEADER;
        r.payload_byte = '0;
        r.frame_opcode = '0;
        r.frame_end = 1'b0;
        r.event_res = EV_NONE;
        clear_after = 1'b0;
        lim64 = {32'd0, limit};
        case (s.ph)
            PH_CLOSED: begin
                r.kind = KIND_CLOSED;
            end
            PH_FIRST: begin
                s.lead_byte = b;
                r.frame_opcode = b[3:0];
                s.hdr_count = 4'd1;
                s.ph = PH_HEADER;
            end
            PH_HEADER: begin
                r.frame_opcode = s.lead_byte[3:0];
                if (s.hdr_count <= 4'd1) begin
                    s.masked = b[7];
                    s.len_code = b[6:0];
                    s.bytes_left = (b[6:0] < LEN_CODE_16) ? {57'd0, b[6:0]} : 64'd0;
                    s.mask_key = '0;
                end
                ext_len = (s.len_code == LEN_CODE_16) ? 4'd2 :
                          (s.len_code == LEN_CODE_64) ? 4'd8 : 4'd0;
                if (s.hdr_count > 4'd1) begin
                    if (s.hdr_count < 4'd2 + ext_len) begin
                        s.bytes_left = {s.bytes_left[55:0], b};
                    end else begin
                        s.mask_key = {s.mask_key[23:0], b};
                    end
                end
                hdr_len = 4'd2 + ext_len + (s.masked ? 4'd4 : 4'd0);
                s.hdr_count = s.hdr_count + 4'd1;
                // Header complete: size check, then empty frame or payload.
                if (s.hdr_count >= hdr_len) begin
                    if (s.bytes_left > lim64 || {32'd0, s.msg_bytes} > lim64 - s.bytes_left) begin
                        r.event_res = EV_TOO_BIG;
                        s.ph = PH_CLOSED;
                    end else if (s.bytes_left == 64'd0) begin
                        r.frame_end = 1'b1;
                        r.event_res = frame_event(s);
                        clear_after = (r.event_res != EV_FRAGMENT);
                    end else begin
                        s.ph = PH_PAYLOAD;
                        s.key_pos = '0;
                    end
                end
            end
            default: begin
                r.kind = KIND_PAYLOAD;
                r.frame_opcode = s.lead_byte[3:0];
                key_word = s.mask_key >> (8 * (3 - int'(s.key_pos)));
                r.payload_byte = b ^ (s.masked ? key_word[7:0] : 8'h00);
                s.key_pos = s.key_pos + 2'd1;
                if (s.msg_bytes != '1) begin
                    s.msg_bytes = s.msg_bytes + 32'd1;
                end
                s.bytes_left = s.bytes_left - 64'd1;
                if (s.bytes_left == 64'd0) begin
                    r.frame_end = 1'b1;
                    r.event_res = frame_event(s);
                    clear_after = (r.event_res != EV_FRAGMENT);
                end
            end
        endcase
        r.message_length = s.msg_bytes;
        if (clear_after) begin
            s.msg_bytes = '0;
        end
        return r;
    endfunction

    // Queue one byte and advance the planning copy of the state.
    task automatic queue_byte(input logic [7:0] b);
        void'(deframe_byte(plan_st, b, plan_limit));
        byte_queue.push_back(b);
        planned++;
    endtask

    // Queue a whole frame. The length form is 0 for 7-bit, 1 for 16-bit, 2 for 64-bit.
    task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic masked, input int unsigned form,
                               input logic [63:0] len);
        logic [31:0] key;
        logic [6:0]  code;
        logic [63:0] j;
        key = $urandom();
        code = (form == 0) ? len[6:0] : (form == 1) ? LEN_CODE_16 : LEN_CODE_64;
        queue_byte({fin, rsv, op});
        queue_byte({masked, code});
        if (form == 1) begin
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
        end else if (form == 2) begin
            for (int i = 7; i >= 0; i--) begin
                queue_byte(len[8 * i +: 8]);
            end
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--) begin
                queue_byte(key[8 * i +: 8]);
            end
        end
        // An oversized header closes the connection, so no payload follows it.
        for (j = 64'd0; j < len && plan_st.ph != PH_CLOSED; j++) begin
            queue_byte(8'($urandom_range(255, 0)));
        end
    endtask

    // Random well-formed frame that stays within the message size limit.
    task automatic queue_random_frame();
        logic        fin;
        logic [3:0]  op;
        logic [63:0] room;
        logic [63:0] len;
        int unsigned pick;
        int unsigned form;
        fin = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 50) begin
            op = 4'($urandom_range(2, 0));
        end else begin
            op = 4'($urandom_range(15, 0));
        end
        if (fin && op == OP_CLOSE) begin
            op = OP_PING;
        end
        room = {32'd0, plan_limit} - {32'd0, plan_st.msg_bytes};
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
            len = 64'($urandom_range(3, 0));
        end else if (pick < 70) begin
            len = 64'($urandom_range(12, 0));
        end else if (pick < 95) begin
            len = 64'($urandom_range(40, 13));
        end else begin
            len = 64'($urandom_range(300, 126));
        end
        if (len > room) begin
            len = room;
        end
        pick = $urandom_range(99, 0);
        if (len >= 64'd126) begin
            form = $urandom_range(2, 1);
        end else if (pick < 80) begin
            form = 0;
        end else if (pick < 90) begin
            form = 1;
        end else begin
            form = 2;
        end
        queue_frame(fin, 3'($urandom_range(7, 0)), op, $urandom_range(99, 0) < 70, form, len);
    endtask

    // Random frames, then an empty final frame if a message is still open, so that a
    // later limit never starts below the bytes already accumulated.
    task automatic fill_random(input int unsigned count);
        planned = 0;
        while (planned < count) begin
            queue_random_frame();
        end
        if (plan_st.msg_bytes != 32'd0) begin
            queue_frame(1'b1, 3'd0, OP_CONT, 1'b0, 0, 64'd0);
        end
    endtask

    // Wait until every queued byte has been taken and every result beat has arrived.
    task automatic drain();
        while (byte_queue.size() != 0 || s_valid || expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_limit(input logic [31:0] value);
        drain();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        live_limit = value;
        plan_limit = value;
        @(posedge aclk);
    endtask

    // Driver: offers bytes and toggles m_ready at the falling edge.
    always @(negedge aclk) begin : driver
        logic       hold_valid;
        logic [7:0] next_byte;
        hold_valid = s_valid && (taken_count != offered_count);
        next_byte = s_rx_byte;
        if (aresetn && !hold_valid && byte_queue.size() != 0 &&
            (quiet || $urandom_range(99, 0) >= IDLE_PCT)) begin
            next_byte = byte_queue.pop_front();
            hold_valid = 1'b1;
            offered_count++;
        end
        s_valid <= hold_valid;
        s_rx_byte <= next_byte;
        m_ready <= aresetn && (quiet || $urandom_range(99, 0) >= IDLE_PCT);
    end

    // Monitor: predicts on each accepted input beat and checks each result beat.
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expect_q.push_back(deframe_byte(live_st, s_rx_byte, live_limit));
                taken_count++;
            end
            if (m_valid && m_ready) begin
                if (expect_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result beat at %0t: kind %0d byte %02h",
                                 $realtime, m_kind, m_payload_byte);
                    end
                    fail_count++;
                end else begin
                    want = expect_q.pop_front();
                    if (m_kind !== want.kind || m_payload_byte !== want.payload_byte ||
                        m_frame_opcode !== want.frame_opcode ||
                        m_frame_end !== want.frame_end || m_event_res !== want.event_res ||
                        m_message_length !== want.message_length) begin
                        if (fail_count < 10) begin
                            $display({"mismatch at %0t: exp kind %0d byte %02h op %0d end %0b",
                                      " ev %0d len %0d"}, $realtime, want.kind,
                                     want.payload_byte, want.frame_opcode, want.frame_end,
                                     want.event_res, want.message_length);
                            $display("    got kind %0d byte %02h op %0d end %0b ev %0d len %0d",
                                     m_kind, m_payload_byte, m_frame_opcode, m_frame_end,
                                     m_event_res, m_message_length);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        logic [63:0] room;
        logic [63:0] len;
        live_st = idle_state();
        plan_st = idle_state();
        live_limit = DEFAULT_MAX_MESSAGE;
        plan_limit = DEFAULT_MAX_MESSAGE;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset limit.
        // Empty final text frame: the event comes on the last header byte.
        queue_byte(8'h81);
        queue_byte(8'h00);
        // Text fragment of one byte, then an empty final continuation with 16-bit length.
        queue_byte(8'h01);
        queue_byte(8'h01);
        queue_byte(8'hff);
        queue_byte(8'h80);
        queue_byte(8'h7e);
        queue_byte(8'h00);
        queue_byte(8'h00);
        // Masked ping carrying the extreme byte values.
        queue_byte(8'h89);
        queue_byte(8'h82);
        queue_byte(8'ha5);
        queue_byte(8'h5a);
        queue_byte(8'hff);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hff);
        // Close without FIN counts as a fragment.
        queue_byte(8'h08);
        queue_byte(8'h00);
        // Pong, then an unknown opcode with all RSV bits set.
        queue_byte(8'h8a);
        queue_byte(8'h00);
        queue_byte(8'hf3);
        queue_byte(8'h00);

        // Random phases across several limits.
        set_limit(32'd1);
        fill_random(150);
        set_limit(32'hffff_ffff);
        quiet = 1'b1;
        fill_random(300);
        drain();
        quiet = 1'b0;
        set_limit($urandom_range(64, 1));
        fill_random(250);
        set_limit($urandom() | 32'd1);
        fill_random(400);

        // End of the connection: either a close frame or an oversized header.
        room = {32'd0, plan_limit} - {32'd0, plan_st.msg_bytes};
        if ($urandom_range(1, 0) == 1) begin
            len = 64'($urandom_range(5, 0));
            if (len > room) begin
                len = room;
            end
            queue_frame(1'b1, 3'd0, OP_CLOSE, 1'($urandom_range(1, 0)), 0, len);
        end else if (room < 64'd125) begin
            queue_frame(1'($urandom_range(1, 0)), 3'd0, OP_BIN, 1'($urandom_range(1, 0)), 0,
                        room + 64'd1);
        end else begin
            len = {1'b1, 31'($urandom()), 32'($urandom())};
            queue_frame(1'($urandom_range(1, 0)), 3'd0, OP_TEXT, 1'($urandom_range(1, 0)), 2,
                        len);
        end
        // Bytes after the connection is closed are dropped.
        repeat (8) queue_byte(8'($urandom_range(255, 0)));

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
